// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bprgb_pkg.sv
`default_nettype none
package bprgb_pkg;

  localparam int ENTRIES_PER_BANK = 4096;
  localparam int BANK_COUNT       = 2;
  localparam int IDX_W            = $clog2(ENTRIES_PER_BANK);
  localparam int BANK_W           = $clog2(BANK_COUNT);
  localparam int SLOT_W           = BANK_W + IDX_W;
  localparam int DEPTH            = BANK_COUNT * ENTRIES_PER_BANK;

  typedef enum logic [1:0] {
    REQ_BYTE_WR = 2'd0,
    REQ_WORD_WR = 2'd1,
    REQ_LOOKUP  = 2'd2,
    REQ_BANK    = 2'd3
  } req_t;

  typedef struct packed {
    logic              we_hi;
    logic              we_lo;
    logic [SLOT_W-1:0] addr;
    logic [15:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } mem_rd_t;

endpackage
`default_nettype wire

// File: rtl/bprgb_bank_mem.sv
`default_nettype none
module bprgb_bank_mem
  import bprgb_pkg::*;
(
  input  wire logic    clk,
  input  wire mem_wr_t wr,
  input  wire mem_rd_t rd,
  output logic [15:0]  rd_data
);

  // Each byte lane is a memory of its own, so a byte write needs no read.
  logic [7:0] mem_hi [DEPTH];
  logic [7:0] mem_lo [DEPTH];
  logic [7:0] rd_hi_r;
  logic [7:0] rd_lo_r;

  always_ff @(posedge clk) begin
    if (wr.we_hi) begin
      mem_hi[wr.addr] <= wr.data[15:8];
    end
    if (rd.en) begin
      rd_hi_r <= mem_hi[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_lo) begin
      mem_lo[wr.addr] <= wr.data[7:0];
    end
    if (rd.en) begin
      rd_lo_r <= mem_lo[rd.addr];
    end
  end

  assign rd_data = {rd_hi_r, rd_lo_r};

endmodule
`default_nettype wire

// File: rtl/banked_palette_ram_rgb_convert.sv
// Banked palette RAM with RGB expansion.
// Input channel: in_valid, in_stall and the request fields. A word is taken
// at a rising edge with in_valid high and in_stall low. Byte and word writes
// go to the active bank, a bank select changes the active bank for the words
// that follow, and a lookup reads one entry of the active bank.
// Output channel: out_valid, out_stall, out_red, out_green, out_blue and
// out_raw_colour. Only lookups give a result word.
// Throughput is one word per cycle while in_stall is low; a lookup result is
// registered first in the read port of the palette memory and then in the
// output register before out_valid rises.
// A write is seen by any lookup taken in a later cycle.
// When out_stall holds a result, one further lookup may wait at the memory
// output; after that in_stall rises until the output moves again.
// Reset selects bank 0 and empties the pipeline; palette contents are not
// cleared and read as undefined until written.
`default_nettype none
module banked_palette_ram_rgb_convert
  import bprgb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [12:0] in_byte_address,
  input  wire logic [15:0] in_write_data,
  input  wire logic [11:0] in_entry_index,
  input  wire logic        in_new_bank,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [15:0]      out_raw_colour
);

  `include "assert_macros.svh"

  logic              acc;
  logic              advance;
  req_t              req;
  logic              is_lookup;
  logic [BANK_W-1:0] active_bank_r;
  logic [BANK_W-1:0] active_bank_nxt;
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [15:0]       raw_r;
  logic [7:0]        red_r;
  logic [7:0]        green_r;
  logic [7:0]        blue_r;
  logic [15:0]       rd_data;
  mem_wr_t           wr;
  mem_rd_t           rd;

  assign req       = req_t'(in_req_type);
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_vld_r && !advance;
  assign acc       = in_valid && !in_stall;
  assign is_lookup = (req == REQ_LOOKUP);

  always_comb begin
    wr.we_hi = 1'b0;
    wr.we_lo = 1'b0;
    wr.addr  = {active_bank_r, in_byte_address[IDX_W:1]};
    wr.data  = in_write_data;
    case (req)
      REQ_BYTE_WR: begin
        wr.we_hi = acc && !in_byte_address[0];
        wr.we_lo = acc && in_byte_address[0];
        wr.data  = {in_write_data[7:0], in_write_data[7:0]};
      end
      REQ_WORD_WR: begin
        wr.we_hi = acc;
        wr.we_lo = acc;
      end
      default: begin
      end
    endcase
  end

  assign rd.en   = acc && is_lookup;
  assign rd.addr = {active_bank_r, in_entry_index[IDX_W-1:0]};

  bprgb_bank_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_comb begin
    active_bank_nxt = active_bank_r;
    if (acc && (req == REQ_BANK) && (int'(in_new_bank) < BANK_COUNT)) begin
      active_bank_nxt = in_new_bank;
    end
    s1_vld_nxt = s1_vld_r && !advance;
    if (acc && is_lookup) begin
      s1_vld_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bank_r <= '0;
      s1_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      active_bank_r <= active_bank_nxt;
      s1_vld_r      <= s1_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_vld_r) begin
      raw_r   <= rd_data;
      red_r   <= {rd_data[11:8], rd_data[14], rd_data[11:9]};
      green_r <= {rd_data[7:4], rd_data[13], rd_data[7:5]};
      blue_r  <= {rd_data[3:0], rd_data[12], rd_data[3:1]};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_raw_colour = raw_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;

  `ASSERT_IMP(a_stall_needs_held, clk, rst_n, in_stall, s1_vld_r && out_valid_r && out_stall, "input stalled without a held lookup")
  `ASSERT_NXT(a_lookup_staged, clk, rst_n, acc && is_lookup, s1_vld_r, "accepted lookup not staged")
  `ASSERT_IMP(a_out_from_stage, clk, rst_n, $rose(out_valid_r), $past(s1_vld_r), "result word without a staged lookup")
  `ASSERT_NXT(a_held_stays, clk, rst_n, s1_vld_r && !advance, s1_vld_r, "staged lookup lost under stall")

endmodule
`default_nettype wire
